@@ hdl/ffba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, codes and the per-cell control word for the first-fit
// block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 24;
    localparam int HEADER_BYTES = 16;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_IGNORED   = 2'd1,
        STATUS_EXHAUSTED = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_HEAP_BASE  = 1'b0,
        REG_HEAP_LIMIT = 1'b1
    } reg_index_t;

    // capture: latch the size compare; remove: close the gap left by the
    // first hit; insert: push everything one place toward the tail
    typedef struct packed {
        logic capture;
        logic remove;
        logic insert;
    } cell_ctl_t;

endpackage : ffba_pkg
`default_nettype wire

@@ hdl/first_fit_block_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a shifting free table with a bump-pointer fallback.
// ----------------------------------------------------------------------------
// Each command runs through ST_IDLE and ST_EXEC: on the accepting edge every
// table cell compares its size with the request and the bump-pointer end
// address is formed; in ST_EXEC, once the result register is free, the first
// hit is taken and the cell row shifts to close the gap (or to push a released
// block in at the front), and the result beat is loaded into the output
// register. A new command is accepted only after the block returns to ST_IDLE,
// so one command is in flight at a time; a stalled result holds the block in
// ST_EXEC. heap_base writes also reload the bump pointer.
module first_fit_block_allocator #(
    parameter int FREE_SLOTS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // request_size, block_address, released_size
    input  wire logic [0:0]  s_tuser,  // command
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // granted_address, granted_size
    output logic [1:0]       m_tuser   // status
);
    import ffba_pkg::*;

    localparam int CNT_W = $clog2(FREE_SLOTS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    logic                cmd_reg;
    logic [SIZE_W-1:0]   req_reg;
    logic [ADDR_W-1:0]   rel_addr_reg;
    logic [SIZE_W-1:0]   rel_size_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ADDR_W-1:0]   bump_reg;
    logic [ADDR_W-1:0]   limit_reg;
    logic [ADDR_W:0]     end_reg;
    logic [ADDR_W-1:0]   payload_reg;
    logic                m_valid_reg;
    logic [ADDR_W-1:0]   m_addr_reg;
    logic [SIZE_W-1:0]   m_size_reg;
    status_t             m_status_reg;

    logic                accept;
    logic                out_free;
    logic [SIZE_W-1:0]   in_req;
    cell_ctl_t           ctl;
    logic                any_hit;
    logic [ADDR_W-1:0]   hit_addr;
    logic [SIZE_W-1:0]   hit_size;

    logic [ADDR_W-1:0]   cell_addr [FREE_SLOTS];
    logic [SIZE_W-1:0]   cell_size [FREE_SLOTS];
    logic [ADDR_W-1:0]   sel_addr  [FREE_SLOTS];
    logic [SIZE_W-1:0]   sel_size  [FREE_SLOTS];
    logic [FREE_SLOTS:0] found;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign in_req   = s_tdata[23:0];

    always_comb begin
        ctl         = '0;
        ctl.capture = accept;
        if (state_reg == ST_EXEC && out_free) begin
            ctl.remove = (cmd_reg == CMD_ALLOC) && (req_reg != '0);
            ctl.insert = (cmd_reg == CMD_RELEASE) && (rel_addr_reg != '0)
                         && (count_reg < CNT_W'(FREE_SLOTS));
        end
    end

    assign found[0] = 1'b0;

    for (genvar j = 0; j < FREE_SLOTS; j++) begin : g_cell
        logic [ADDR_W-1:0] l_addr;
        logic [SIZE_W-1:0] l_size;
        logic [ADDR_W-1:0] r_addr;
        logic [SIZE_W-1:0] r_size;
        if (j == 0) begin : g_head
            assign l_addr = rel_addr_reg;
            assign l_size = rel_size_reg;
        end else begin : g_body
            assign l_addr = cell_addr[j-1];
            assign l_size = cell_size[j-1];
        end
        if (j == FREE_SLOTS - 1) begin : g_tail
            assign r_addr = '0;
            assign r_size = '0;
        end else begin : g_mid
            assign r_addr = cell_addr[j+1];
            assign r_size = cell_size[j+1];
        end
        ffba_cell #(
            .IDX   (j),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .req_size   (in_req),
            .count      (count_reg),
            .left_addr  (l_addr),
            .left_size  (l_size),
            .right_addr (r_addr),
            .right_size (r_size),
            .found_in   (found[j]),
            .found_out  (found[j+1]),
            .addr       (cell_addr[j]),
            .size       (cell_size[j]),
            .sel_addr   (sel_addr[j]),
            .sel_size   (sel_size[j])
        );
    end

    assign any_hit = found[FREE_SLOTS];

    // at most one cell drives a nonzero select
    always_comb begin
        hit_addr = '0;
        hit_size = '0;
        for (int k = 0; k < FREE_SLOTS; k++) begin
            hit_addr = hit_addr | sel_addr[k];
            hit_size = hit_size | sel_size[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            limit_reg    <= '1;
            bump_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_HEAP_BASE:  bump_reg  <= cfg_wdata;
                    REG_HEAP_LIMIT: limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg      <= s_tuser[0];
                        req_reg      <= in_req;
                        rel_addr_reg <= s_tdata[55:24];
                        rel_size_reg <= s_tdata[79:56];
                        end_reg      <= {1'b0, bump_reg} + (ADDR_W+1)'(HEADER_BYTES)
                                        + (ADDR_W+1)'(in_req);
                        payload_reg  <= bump_reg + ADDR_W'(HEADER_BYTES);
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_addr_reg   <= '0;
                        m_size_reg   <= '0;
                        m_status_reg <= STATUS_DONE;
                        state_reg    <= ST_IDLE;
                        if (cmd_reg == CMD_ALLOC) begin
                            if (req_reg == '0) begin
                                m_status_reg <= STATUS_IGNORED;
                            end else if (any_hit) begin
                                m_addr_reg <= hit_addr;
                                m_size_reg <= hit_size;
                                count_reg  <= count_reg - CNT_W'(1);
                            end else if (end_reg > {1'b0, limit_reg}) begin
                                m_status_reg <= STATUS_EXHAUSTED;
                            end else begin
                                m_addr_reg <= payload_reg;
                                m_size_reg <= req_reg;
                                bump_reg   <= end_reg[ADDR_W-1:0];
                            end
                        end else begin
                            if (rel_addr_reg == '0) begin
                                m_status_reg <= STATUS_IGNORED;
                            end else if (count_reg >= CNT_W'(FREE_SLOTS)) begin
                                m_status_reg <= STATUS_FULL;
                            end else begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_size_reg, m_addr_reg};
    assign m_tuser  = m_status_reg;

endmodule : first_fit_block_allocator
`default_nettype wire

@@ hdl/ffba_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_cell
// One free-table slot: holds an address and size, compares against the
// request, and shifts toward either neighbor on remove or insert.
// ----------------------------------------------------------------------------
module ffba_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  wire logic                         aclk,
    input  wire ffba_pkg::cell_ctl_t          ctl,
    input  wire logic [ffba_pkg::SIZE_W-1:0]  req_size,
    input  wire logic [CNT_W-1:0]             count,
    input  wire logic [ffba_pkg::ADDR_W-1:0]  left_addr,
    input  wire logic [ffba_pkg::SIZE_W-1:0]  left_size,
    input  wire logic [ffba_pkg::ADDR_W-1:0]  right_addr,
    input  wire logic [ffba_pkg::SIZE_W-1:0]  right_size,
    input  wire logic                         found_in,
    output logic                              found_out,
    output logic [ffba_pkg::ADDR_W-1:0]       addr,
    output logic [ffba_pkg::SIZE_W-1:0]       size,
    output logic [ffba_pkg::ADDR_W-1:0]       sel_addr,
    output logic [ffba_pkg::SIZE_W-1:0]       sel_size
);
    import ffba_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              hit_reg;
    logic              first;

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            hit_reg <= (CNT_W'(IDX) < count) && (size_reg >= req_size);
        end
        if (ctl.insert) begin
            addr_reg <= left_addr;
            size_reg <= left_size;
        end else if (ctl.remove && found_out) begin
            // this slot sits at or past the taken entry
            addr_reg <= right_addr;
            size_reg <= right_size;
        end
    end

    assign first     = hit_reg && !found_in;
    assign found_out = found_in || hit_reg;
    assign addr      = addr_reg;
    assign size      = size_reg;
    assign sel_addr  = first ? addr_reg : '0;
    assign sel_size  = first ? size_reg : '0;

endmodule : ffba_cell
`default_nettype wire

@@ hdl/ffba_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level assertions for the first-fit block allocator, bound to the top.
// ----------------------------------------------------------------------------
module ffba_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    import ffba_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one command in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while previous one still executing");

    // any status other than done carries an empty grant
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_DONE) |-> (m_tdata == '0))
        else $error("non-done status with nonzero grant");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a release never grants anything
    a_release_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == CMD_RELEASE) |=> ##1
        (m_tvalid && !$past(m_tvalid, 1)) |-> (m_tdata == '0))
        else $error("release produced a grant");

endmodule : ffba_checker

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
